// ===== sv/pixel_to_plane_homography_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the planar homography block
// Short forms for clocked properties with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_PLANE_HOMOGRAPHY_MACROS_SVH
`define PIXEL_TO_PLANE_HOMOGRAPHY_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/pph_pkg.sv =====
// ----------------------------------------------------------------------------
// Planar homography package
// Widths, register codes, reset coefficients and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package pph_pkg;

    localparam int PIX_W      = 12;
    localparam int COEF_W     = 40;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = SUM_W;
    localparam int REM_W      = MAG_W + 1;
    localparam int COEF_FRAC  = 30;
    localparam int DEGEN_SH   = COEF_FRAC - 20;
    localparam int FRAC_OUT   = 16;
    localparam int OUT_W      = 32;
    localparam int Q_W        = OUT_W + 1;
    localparam int OVF_SH     = Q_W - FRAC_OUT;
    localparam int NUM_REGS   = 8;
    localparam int IDX_W      = 3;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [Q_W-1:0]           quo_t;
    typedef logic [OUT_W-1:0]         out_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_PX    = 3'd0,
        REG_ROW0_PY    = 3'd1,
        REG_ROW0_CONST = 3'd2,
        REG_ROW1_PX    = 3'd3,
        REG_ROW1_PY    = 3'd4,
        REG_ROW1_CONST = 3'd5,
        REG_ROW2_PX    = 3'd6,
        REG_ROW2_PY    = 3'd7
    } reg_idx_t;

    localparam coef_t RST_ROW0_PX    =  40'sd1175308835;
    localparam coef_t RST_ROW0_PY    = -40'sd70394557;
    localparam coef_t RST_ROW0_CONST =  40'sd31113097095;
    localparam coef_t RST_ROW1_PX    = -40'sd71200583;
    localparam coef_t RST_ROW1_PY    = -40'sd1233806461;
    localparam coef_t RST_ROW1_CONST =  40'sd264952693895;
    localparam coef_t RST_ROW2_PX    = -40'sd201004;
    localparam coef_t RST_ROW2_PY    = -40'sd120860;

    typedef struct packed {
        coef_t row0_px;
        coef_t row0_py;
        coef_t row0_const;
        coef_t row1_px;
        coef_t row1_py;
        coef_t row1_const;
        coef_t row2_px;
        coef_t row2_py;
    } coef_set_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        mag_t mag;
    } num_prep_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } div_flags_t;

endpackage

`default_nettype wire

// ===== sv/pph_if.sv =====
// ----------------------------------------------------------------------------
// Planar homography channels
// Valid/ready channels for pixel requests and desk-plane results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pph_pix_if;
    logic          valid;
    logic          ready;
    pph_pkg::pix_t pixel_col;
    pph_pkg::pix_t pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface pph_plane_if;
    logic          valid;
    logic          ready;
    pph_pkg::out_t plane_x;
    pph_pkg::out_t plane_y;
    logic          degenerate;

    modport source (output valid, output plane_x, output plane_y, output degenerate,
                    input ready);
    modport sink   (input valid, input plane_x, input plane_y, input degenerate,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/pph_mac.sv =====
// ----------------------------------------------------------------------------
// Homography multiply-accumulate
// Two stages: six coefficient products, then the three row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pph_mac (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire pph_pkg::pix_t      px,
    input  wire pph_pkg::pix_t      py,
    input  wire pph_pkg::coef_set_t coefs,
    output logic                    out_valid,
    output pph_pkg::sum_t           nx,
    output pph_pkg::sum_t           ny,
    output pph_pkg::sum_t           den
);

    localparam pph_pkg::sum_t DEN_ONE = pph_pkg::sum_t'(1) <<< pph_pkg::COEF_FRAC;

    logic          v1_reg;
    logic          v2_reg;
    pph_pkg::prod_t p_reg [6];
    pph_pkg::prod_t p_next [6];
    pph_pkg::sum_t nx_reg, ny_reg, den_reg;
    pph_pkg::sum_t nx_next, ny_next, den_next;

    always_comb
    begin
        p_next[0] = pph_pkg::prod_t'(coefs.row0_px) * pph_pkg::prod_t'(px);
        p_next[1] = pph_pkg::prod_t'(coefs.row0_py) * pph_pkg::prod_t'(py);
        p_next[2] = pph_pkg::prod_t'(coefs.row1_px) * pph_pkg::prod_t'(px);
        p_next[3] = pph_pkg::prod_t'(coefs.row1_py) * pph_pkg::prod_t'(py);
        p_next[4] = pph_pkg::prod_t'(coefs.row2_px) * pph_pkg::prod_t'(px);
        p_next[5] = pph_pkg::prod_t'(coefs.row2_py) * pph_pkg::prod_t'(py);
    end

    always_comb
    begin
        nx_next  = pph_pkg::sum_t'(p_reg[0]) + pph_pkg::sum_t'(p_reg[1])
                 + pph_pkg::sum_t'(coefs.row0_const);
        ny_next  = pph_pkg::sum_t'(p_reg[2]) + pph_pkg::sum_t'(p_reg[3])
                 + pph_pkg::sum_t'(coefs.row1_const);
        den_next = pph_pkg::sum_t'(p_reg[4]) + pph_pkg::sum_t'(p_reg[5]) + DEN_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= p_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            den_reg <= den_next;
        end
    end

    assign out_valid = v2_reg;
    assign nx        = nx_reg;
    assign ny        = ny_reg;
    assign den       = den_reg;

endmodule

`default_nettype wire

// ===== sv/pph_prep.sv =====
// ----------------------------------------------------------------------------
// Homography division setup
// Takes magnitudes and signs, flags a near-zero denominator and quotient overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module pph_prep (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire pph_pkg::sum_t      nx,
    input  wire pph_pkg::sum_t      ny,
    input  wire pph_pkg::sum_t      den,
    output logic                    out_valid,
    output pph_pkg::num_prep_t      x,
    output pph_pkg::num_prep_t      y,
    output pph_pkg::mag_t           dmag,
    output logic                    degen
);

    localparam int CMP_W = pph_pkg::MAG_W + pph_pkg::OVF_SH;
    localparam pph_pkg::mag_t DEGEN_LIM = pph_pkg::mag_t'(1) << pph_pkg::DEGEN_SH;

    logic               v_reg;
    pph_pkg::num_prep_t x_reg, y_reg, x_next, y_next;
    pph_pkg::mag_t      dmag_reg, dmag_next;
    logic               degen_reg, degen_next;
    logic [CMP_W-1:0]   dlim;

    function automatic pph_pkg::mag_t mag_of(input pph_pkg::sum_t v);
        return v[pph_pkg::SUM_W-1] ? pph_pkg::mag_t'(-v) : pph_pkg::mag_t'(v);
    endfunction

    always_comb
    begin
        dmag_next  = mag_of(den);
        degen_next = dmag_next < DEGEN_LIM;
        dlim       = {dmag_next, pph_pkg::OVF_SH'(0)};
        x_next.mag = mag_of(nx);
        x_next.neg = nx[pph_pkg::SUM_W-1] ^ den[pph_pkg::SUM_W-1];
        x_next.ovf = CMP_W'(x_next.mag) >= dlim;
        y_next.mag = mag_of(ny);
        y_next.neg = ny[pph_pkg::SUM_W-1] ^ den[pph_pkg::SUM_W-1];
        y_next.ovf = CMP_W'(y_next.mag) >= dlim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            dmag_reg  <= dmag_next;
            degen_reg <= degen_next;
        end
    end

    assign out_valid = v_reg;
    assign x         = x_reg;
    assign y         = y_reg;
    assign dmag      = dmag_reg;
    assign degen     = degen_reg;

endmodule

`default_nettype wire

// ===== sv/pph_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; the quotient shifts in behind the dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module pph_div (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire pph_pkg::num_prep_t num,
    input  wire pph_pkg::mag_t      d,
    output pph_pkg::quo_t           q,
    output pph_pkg::div_flags_t     flags
);

    localparam int NST = pph_pkg::Q_W;

    pph_pkg::rem_t       rem_reg   [NST];
    pph_pkg::quo_t       low_reg   [NST];
    pph_pkg::mag_t       d_reg     [NST];
    pph_pkg::div_flags_t flag_reg  [NST];
    pph_pkg::rem_t       rem_next  [NST];
    pph_pkg::quo_t       low_next  [NST];
    pph_pkg::rem_t       rem_in    [NST];
    pph_pkg::quo_t       low_in    [NST];
    pph_pkg::mag_t       d_in      [NST];
    pph_pkg::div_flags_t flag_in   [NST];

    assign rem_in[0]      = pph_pkg::rem_t'(num.mag >> pph_pkg::OVF_SH);
    assign low_in[0]      = pph_pkg::quo_t'({num.mag, pph_pkg::FRAC_OUT'(0)});
    assign d_in[0]        = d;
    assign flag_in[0].neg = num.neg;
    assign flag_in[0].ovf = num.ovf;

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        pph_pkg::rem_t trial;
        logic          ge;

        if (s > 0)
        begin : g_link
            assign rem_in[s]  = rem_reg[s-1];
            assign low_in[s]  = low_reg[s-1];
            assign d_in[s]    = d_reg[s-1];
            assign flag_in[s] = flag_reg[s-1];
        end

        always_comb
        begin
            trial       = {rem_in[s][pph_pkg::REM_W-2:0], low_in[s][pph_pkg::Q_W-1]};
            ge          = trial >= {1'b0, d_in[s]};
            rem_next[s] = ge ? (trial - {1'b0, d_in[s]}) : trial;
            low_next[s] = {low_in[s][pph_pkg::Q_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next[s];
                low_reg[s]  <= low_next[s];
                d_reg[s]    <= d_in[s];
                flag_reg[s] <= flag_in[s];
            end
        end
    end

    assign q     = low_reg[NST-1];
    assign flags = flag_reg[NST-1];

endmodule

`default_nettype wire

// ===== sv/pixel_to_plane_homography.sv =====
// ----------------------------------------------------------------------------
// Pixel to desk-plane homography
// Maps a signed pixel pair through a 3x3 projective transform to Q15.16 mm.
// ----------------------------------------------------------------------------
// The block accepts one pixel request per clock unless the output stalls and
// returns one result per request, in order, through two multiply-accumulate
// stages, one division setup stage, 33 divider stages and the output register.
// The rate is set by the two dividers, unrolled one quotient bit per stage so
// that a new request enters every cycle, but an output stall freezes the whole
// pipeline. Coefficients must be written only while no request is in flight.
`default_nettype none

`include "pixel_to_plane_homography_macros.svh"

module pixel_to_plane_homography (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    pph_pix_if.sink                         pix,
    pph_plane_if.source                     plane,
    input  wire logic                       cfg_we,
    input  wire logic [pph_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [pph_pkg::COEF_W-1:0] cfg_data
);

    localparam int NST = pph_pkg::Q_W;
    localparam pph_pkg::out_t POS_MAX = {1'b0, {(pph_pkg::OUT_W-1){1'b1}}};
    localparam pph_pkg::out_t NEG_MIN = {1'b1, {(pph_pkg::OUT_W-1){1'b0}}};

    pph_pkg::coef_set_t  coefs_reg;
    logic                adv;
    logic                mac_valid, prep_valid;
    pph_pkg::sum_t       nx, ny, den;
    pph_pkg::num_prep_t  x_prep, y_prep;
    pph_pkg::mag_t       dmag;
    logic                degen;
    logic                dv_reg     [NST];
    logic                dg_reg     [NST];
    pph_pkg::quo_t       qx, qy;
    pph_pkg::div_flags_t fx, fy;
    logic                out_valid_reg;
    pph_pkg::out_t       x_reg, y_reg, x_next, y_next;
    logic                degen_reg;

    function automatic pph_pkg::out_t saturate(input pph_pkg::quo_t qv,
                                               input pph_pkg::div_flags_t f);
        pph_pkg::out_t r;
        if (f.neg)
        begin
            if (f.ovf || qv > pph_pkg::quo_t'(NEG_MIN))
                r = NEG_MIN;
            else
                r = -pph_pkg::out_t'(qv);
        end
        else
        begin
            if (f.ovf || qv > pph_pkg::quo_t'(POS_MAX))
                r = POS_MAX;
            else
                r = pph_pkg::out_t'(qv);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.row0_px    <= pph_pkg::RST_ROW0_PX;
            coefs_reg.row0_py    <= pph_pkg::RST_ROW0_PY;
            coefs_reg.row0_const <= pph_pkg::RST_ROW0_CONST;
            coefs_reg.row1_px    <= pph_pkg::RST_ROW1_PX;
            coefs_reg.row1_py    <= pph_pkg::RST_ROW1_PY;
            coefs_reg.row1_const <= pph_pkg::RST_ROW1_CONST;
            coefs_reg.row2_px    <= pph_pkg::RST_ROW2_PX;
            coefs_reg.row2_py    <= pph_pkg::RST_ROW2_PY;
        end
        else if (cfg_we)
        begin
            unique case (pph_pkg::reg_idx_t'(cfg_index))
                pph_pkg::REG_ROW0_PX:    coefs_reg.row0_px    <= cfg_data;
                pph_pkg::REG_ROW0_PY:    coefs_reg.row0_py    <= cfg_data;
                pph_pkg::REG_ROW0_CONST: coefs_reg.row0_const <= cfg_data;
                pph_pkg::REG_ROW1_PX:    coefs_reg.row1_px    <= cfg_data;
                pph_pkg::REG_ROW1_PY:    coefs_reg.row1_py    <= cfg_data;
                pph_pkg::REG_ROW1_CONST: coefs_reg.row1_const <= cfg_data;
                pph_pkg::REG_ROW2_PX:    coefs_reg.row2_px    <= cfg_data;
                pph_pkg::REG_ROW2_PY:    coefs_reg.row2_py    <= cfg_data;
                default:                 coefs_reg            <= coefs_reg;
            endcase
        end
    end

    assign adv       = !out_valid_reg || plane.ready;
    assign pix.ready = adv;

    pph_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pix.valid),
        .px        (pix.pixel_col),
        .py        (pix.pixel_row),
        .coefs     (coefs_reg),
        .out_valid (mac_valid),
        .nx        (nx),
        .ny        (ny),
        .den       (den)
    );

    pph_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mac_valid),
        .nx        (nx),
        .ny        (ny),
        .den       (den),
        .out_valid (prep_valid),
        .x         (x_prep),
        .y         (y_prep),
        .dmag      (dmag),
        .degen     (degen)
    );

    pph_div u_div_x (
        .clk   (clk),
        .en    (adv),
        .num   (x_prep),
        .d     (dmag),
        .q     (qx),
        .flags (fx)
    );

    pph_div u_div_y (
        .clk   (clk),
        .en    (adv),
        .num   (y_prep),
        .d     (dmag),
        .q     (qy),
        .flags (fy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= prep_valid;
            for (int i = 1; i < NST; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
            out_valid_reg <= dv_reg[NST-1];
        end
    end

    always_comb
    begin
        x_next = dg_reg[NST-1] ? '0 : saturate(qx, fx);
        y_next = dg_reg[NST-1] ? '0 : saturate(qy, fy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dg_reg[0] <= degen;
            for (int i = 1; i < NST; i++)
            begin
                dg_reg[i] <= dg_reg[i-1];
            end
            x_reg     <= x_next;
            y_reg     <= y_next;
            degen_reg <= dg_reg[NST-1];
        end
    end

    assign plane.valid      = out_valid_reg;
    assign plane.plane_x    = x_reg;
    assign plane.plane_y    = y_reg;
    assign plane.degenerate = degen_reg;

    `PPH_ASSERT_SAME(a_degen_zero, clk, rst_n, plane.valid && plane.degenerate, plane.plane_x == '0 && plane.plane_y == '0)
    `PPH_ASSERT_NEXT(a_stall_holds, clk, rst_n, plane.valid && !plane.ready, $stable({plane.valid, plane.plane_x, plane.plane_y, plane.degenerate}))
    `PPH_ASSERT_NEXT(a_div_to_out, clk, rst_n, adv && dv_reg[NST-1], plane.valid)

endmodule

`default_nettype wire

// ===== tb/tb_pixel_to_plane_homography.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the pixel to desk-plane homography
// Drives pixel requests through valid/ready channels with bursty input and a
// stalling receiver, predicts each projected point in a scoreboard class and
// checks every result in order across several coefficient settings.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    pph_pkg::out_t x;
    pph_pkg::out_t y;
    logic          degenerate;
} plane_point_t;

class desk_scoreboard;
    pph_pkg::coef_t coefs[pph_pkg::NUM_REGS];
    plane_point_t   pending_points[$];
    int             errors;

    function new();
        coefs[pph_pkg::REG_ROW0_PX]    = pph_pkg::RST_ROW0_PX;
        coefs[pph_pkg::REG_ROW0_PY]    = pph_pkg::RST_ROW0_PY;
        coefs[pph_pkg::REG_ROW0_CONST] = pph_pkg::RST_ROW0_CONST;
        coefs[pph_pkg::REG_ROW1_PX]    = pph_pkg::RST_ROW1_PX;
        coefs[pph_pkg::REG_ROW1_PY]    = pph_pkg::RST_ROW1_PY;
        coefs[pph_pkg::REG_ROW1_CONST] = pph_pkg::RST_ROW1_CONST;
        coefs[pph_pkg::REG_ROW2_PX]    = pph_pkg::RST_ROW2_PX;
        coefs[pph_pkg::REG_ROW2_PY]    = pph_pkg::RST_ROW2_PY;
        errors = 0;
    endfunction

    function pph_pkg::out_t divide_q(longint num, longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        if (num == 0)
            return '0;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        q = (n << pph_pkg::FRAC_OUT) / d;
        if (neg)
        begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return pph_pkg::out_t'(-q);
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return pph_pkg::out_t'(q);
    endfunction

    function void note(pph_pkg::pix_t col, pph_pkg::pix_t row);
        longint       px;
        longint       py;
        longint       den;
        longint       nx;
        longint       ny;
        plane_point_t p;
        px  = longint'(col);
        py  = longint'(row);
        den = longint'(coefs[pph_pkg::REG_ROW2_PX]) * px
              + longint'(coefs[pph_pkg::REG_ROW2_PY]) * py
              + (64'sd1 <<< pph_pkg::COEF_FRAC);
        nx  = longint'(coefs[pph_pkg::REG_ROW0_PX]) * px
              + longint'(coefs[pph_pkg::REG_ROW0_PY]) * py
              + longint'(coefs[pph_pkg::REG_ROW0_CONST]);
        ny  = longint'(coefs[pph_pkg::REG_ROW1_PX]) * px
              + longint'(coefs[pph_pkg::REG_ROW1_PY]) * py
              + longint'(coefs[pph_pkg::REG_ROW1_CONST]);
        if (den > -(64'sd1 <<< pph_pkg::DEGEN_SH) && den < (64'sd1 <<< pph_pkg::DEGEN_SH))
        begin
            p.x = '0;
            p.y = '0;
            p.degenerate = 1'b1;
        end
        else
        begin
            p.x = divide_q(nx, den);
            p.y = divide_q(ny, den);
            p.degenerate = 1'b0;
        end
        pending_points.push_back(p);
    endfunction

    function void check(pph_pkg::out_t x, pph_pkg::out_t y, logic degenerate);
        plane_point_t p;
        if (pending_points.size() == 0)
        begin
            $display("%0t: unexpected result x=%h y=%h degenerate=%b",
                     $time, x, y, degenerate);
            errors++;
            return;
        end
        p = pending_points.pop_front();
        if (x !== p.x)
        begin
            $display("%0t: plane_x expected %h actual %h", $time, p.x, x);
            errors++;
        end
        if (y !== p.y)
        begin
            $display("%0t: plane_y expected %h actual %h", $time, p.y, y);
            errors++;
        end
        if (degenerate !== p.degenerate)
        begin
            $display("%0t: degenerate expected %b actual %b",
                     $time, p.degenerate, degenerate);
            errors++;
        end
    endfunction
endclass

module tb_pixel_to_plane_homography;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [pph_pkg::IDX_W-1:0]  cfg_index;
    logic [pph_pkg::COEF_W-1:0] cfg_data;
    int                         received;
    int                         burst_left;

    pph_pix_if   pix ();
    pph_plane_if plane ();

    desk_scoreboard book;

    pixel_to_plane_homography dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix.sink),
        .plane     (plane.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #20ms;
        $display("** pixel_to_plane_homography: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && plane.valid && plane.ready)
        begin
            book.check(plane.plane_x, plane.plane_y, plane.degenerate);
            received++;
        end
    end

    // The receiver mixes full-rate, random and patterned stalls; once it holds
    // off long enough for the pipeline to fill and block new requests.
    initial
    begin
        int  mode;
        int  span;
        int  period;
        bit  long_hold_done;
        plane.ready = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && received >= 300)
            begin
                long_hold_done = 1'b1;
                @(negedge clk);
                plane.ready = 1'b0;
                repeat (250) @(negedge clk);
            end
            mode   = $urandom_range(0, 2);
            span   = $urandom_range(5, 60);
            period = $urandom_range(2, 5);
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (mode)
                    0: plane.ready = 1'b1;
                    1: plane.ready = 1'($urandom_range(0, 1));
                    default: plane.ready = (i % period) != 0;
                endcase
            end
        end
    end

    task automatic send_pixel(pph_pkg::pix_t col, pph_pkg::pix_t row);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                @(negedge clk);
                pix.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        pix.valid     = 1'b1;
        pix.pixel_col = col;
        pix.pixel_row = row;
        do
            @(posedge clk);
        while (!pix.ready);
        book.note(col, row);
    endtask

    task automatic settle();
        @(negedge clk);
        pix.valid = 1'b0;
        while (book.pending_points.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic write_coef(pph_pkg::reg_idx_t idx, pph_pkg::coef_t value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        book.coefs[idx] = value;
    endtask

    function automatic pph_pkg::coef_t rand_coef();
        logic [63:0] raw;
        int          w;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return pph_pkg::coef_t'(raw);
            1:
            begin
                w = $urandom_range(1, 24);
                return pph_pkg::coef_t'($signed(raw << (64 - w)) >>> (64 - w));
            end
            default:
            begin
                w = $urandom_range(25, 37);
                return pph_pkg::coef_t'($signed(raw << (64 - w)) >>> (64 - w));
            end
        endcase
    endfunction

    function automatic pph_pkg::pix_t rand_pixel();
        case ($urandom_range(0, 7))
            0: return pph_pkg::pix_t'(-2048);
            1: return pph_pkg::pix_t'(2047);
            2: return pph_pkg::pix_t'($urandom_range(0, 7) - 4);
            default: return pph_pkg::pix_t'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(), rand_pixel());
    endtask

    initial
    begin
        book       = new();
        received   = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        pix.valid     = 1'b0;
        pix.pixel_col = '0;
        pix.pixel_row = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pixel(12'sd0, 12'sd0);
        send_pixel(-12'sd2048, -12'sd2048);
        send_pixel(12'sd2047, 12'sd2047);
        send_pixel(-12'sd2048, 12'sd2047);
        send_pixel(12'sd2047, -12'sd2048);
        send_pixel(12'sd320, 12'sd240);
        random_pixels(400);
        settle();

        // Denominator is 1 - px + py / 2^30, so near px = 1 it crosses zero
        // and small denominators drive the quotients into saturation.
        write_coef(pph_pkg::REG_ROW0_PX, 40'sh7F_FFFF_FFFF);
        write_coef(pph_pkg::REG_ROW0_PY, 40'sh80_0000_0000);
        write_coef(pph_pkg::REG_ROW0_CONST, '0);
        write_coef(pph_pkg::REG_ROW1_PX, 40'sh80_0000_0000);
        write_coef(pph_pkg::REG_ROW1_PY, 40'sh7F_FFFF_FFFF);
        write_coef(pph_pkg::REG_ROW1_CONST, 40'sh7F_FFFF_FFFF);
        write_coef(pph_pkg::REG_ROW2_PX, -(40'sd1 <<< pph_pkg::COEF_FRAC));
        write_coef(pph_pkg::REG_ROW2_PY, 40'sd1);
        send_pixel(12'sd0, 12'sd0);
        send_pixel(12'sd1, 12'sd0);
        send_pixel(12'sd1, 12'sd1023);
        send_pixel(12'sd1, -12'sd1023);
        send_pixel(12'sd1, 12'sd1024);
        send_pixel(12'sd1, -12'sd1024);
        send_pixel(12'sd1, 12'sd2047);
        send_pixel(12'sd1, -12'sd2048);
        send_pixel(12'sd2, 12'sd0);
        send_pixel(-12'sd2048, 12'sd2047);
        send_pixel(12'sd2047, -12'sd2048);
        random_pixels(150);
        settle();

        write_coef(pph_pkg::REG_ROW2_PX, 40'sh7F_FFFF_FFFF);
        write_coef(pph_pkg::REG_ROW2_PY, 40'sh80_0000_0000);
        send_pixel(12'sd0, 12'sd0);
        send_pixel(12'sd1, 12'sd1);
        send_pixel(12'sd2047, -12'sd2048);
        send_pixel(-12'sd2048, 12'sd2047);
        settle();

        for (int s = 0; s < 4; s++)
        begin
            for (int r = 0; r < pph_pkg::NUM_REGS; r++)
                write_coef(pph_pkg::reg_idx_t'(r), rand_coef());
            random_pixels(200);
            settle();
        end

        if (book.errors == 0 && book.pending_points.size() == 0)
            $display("** pixel_to_plane_homography: PASSED **");
        else
            $display("** pixel_to_plane_homography: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/pph_pkg.sv
sv/pph_if.sv
sv/pph_mac.sv
sv/pph_prep.sv
sv/pph_div.sv
sv/pixel_to_plane_homography.sv
tb/tb_pixel_to_plane_homography.sv
